/* hw/rtl/segment_intersection_core_macros.svh */
// Assertion macros for the segment intersection core.
`ifndef SEGMENT_INTERSECTION_CORE_MACROS_SVH
`define SEGMENT_INTERSECTION_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge outside reset.
`define SEGX_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("segment core check failed: same cycle");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define SEGX_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("segment core check failed: next cycle");
`else
`define SEGX_ASSERT_NOW(label, ante, cons)
`define SEGX_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/segx_pkg.sv */
// Shared constants and types of the segment intersection core.
package segx_pkg;
   // Width of every coordinate and crossing port.
   localparam int PORT_WIDTH = 32;
   // Width of the edge tolerance register.
   localparam int TOL_WIDTH = 32;
   typedef logic [PORT_WIDTH-1:0] port_word_type;
   typedef logic [TOL_WIDTH-1:0]  tol_word_type;
endpackage

/* hw/rtl/segment_intersection_core.sv */
// Pipelined crossing point of two line segments in fixed point.
//
//  Channel   Handshake              Word
//  req       req_valid / req_stall  eight end point coordinates
//  rsp       rsp_valid / rsp_stall  hit flag, crossing x and y
//  csr       csr_valid / csr_ready  edge tolerance (always ready)
//
// One word enters per cycle while req_stall is low.
// The restoring divider produces one quotient bit per stage.
// Reset (synchronous, active high) clears all valid bits and the tolerance.
// The pipeline advances as a whole; the output register and a one-word skid
// stage let it keep taking words until the skid stage fills after rsp_stall rises.
`include "segment_intersection_core_macros.svh"
module segment_intersection_core
   import segx_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  port_word_type req_first_start_x,
   input  port_word_type req_first_start_y,
   input  port_word_type req_first_end_x,
   input  port_word_type req_first_end_y,
   input  port_word_type req_second_start_x,
   input  port_word_type req_second_start_y,
   input  port_word_type req_second_end_x,
   input  port_word_type req_second_end_y,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_hit,
   output port_word_type rsp_cross_x,
   output port_word_type rsp_cross_y,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  tol_word_type  csr_data
);
   localparam int W   = COORD_WIDTH;
   localparam int DW  = W + 1;            // coordinate differences
   localparam int PW  = 2 * DW;           // one cross product term
   localparam int FW  = PW + 1;           // numerators and denominator
   localparam int TW  = FW + 1;           // tolerance tests
   localparam int NW  = FW + DW;          // numerator times difference
   localparam int LO  = FW / 2;           // split point of the wide multiply
   localparam int HBW = FW - LO;
   localparam int LBW = LO + 1;
   localparam int PHW = HBW + DW;
   localparam int PLW = LBW + DW;
   localparam int SW  = (W + 2 > PORT_WIDTH) ? W + 2 : PORT_WIDTH;

   // Configuration register.
   tol_word_type tol_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_valid) begin
         tol_ff <= csr_data;
      end
   end

   // Global advance: the pipeline moves unless the skid stage is holding a word.
   logic skid_valid_ff;
   logic pipe_en;
   assign pipe_en   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Valid bits of the fixed stages.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, fin_valid_ff;
   logic dv_valid_ff [0:DW];

   // Stage 1: capture coordinates.
   logic signed [W-1:0] s1_x1_ff, s1_y1_ff, s1_x2_ff, s1_y2_ff;
   logic signed [W-1:0] s1_x3_ff, s1_y3_ff, s1_x4_ff, s1_y4_ff;
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_x1_ff <= req_first_start_x[W-1:0];
         s1_y1_ff <= req_first_start_y[W-1:0];
         s1_x2_ff <= req_first_end_x[W-1:0];
         s1_y2_ff <= req_first_end_y[W-1:0];
         s1_x3_ff <= req_second_start_x[W-1:0];
         s1_y3_ff <= req_second_start_y[W-1:0];
         s1_x4_ff <= req_second_end_x[W-1:0];
         s1_y4_ff <= req_second_end_y[W-1:0];
      end
   end

   // Stage 2: differences and the axis-aligned flags.
   logic signed [DW-1:0] s2_ax_in, s2_ay_in, s2_bx_in, s2_by_in, s2_cx_in, s2_cy_in;
   logic signed [DW-1:0] s2_ax_ff, s2_ay_ff, s2_bx_ff, s2_by_ff, s2_cx_ff, s2_cy_ff;
   logic signed [W-1:0]  s2_x1_ff, s2_y1_ff, s2_x2_ff, s2_y2_ff;
   logic signed [W-1:0]  s2_x3_ff, s2_y3_ff, s2_x4_ff, s2_y4_ff;
   logic                 s2_eqx_ff, s2_eqy_ff;
   assign s2_ax_in = DW'(s1_x2_ff) - DW'(s1_x1_ff);
   assign s2_ay_in = DW'(s1_y2_ff) - DW'(s1_y1_ff);
   assign s2_bx_in = DW'(s1_x3_ff) - DW'(s1_x4_ff);
   assign s2_by_in = DW'(s1_y3_ff) - DW'(s1_y4_ff);
   assign s2_cx_in = DW'(s1_x1_ff) - DW'(s1_x3_ff);
   assign s2_cy_in = DW'(s1_y1_ff) - DW'(s1_y3_ff);
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_ax_ff  <= s2_ax_in;
         s2_ay_ff  <= s2_ay_in;
         s2_bx_ff  <= s2_bx_in;
         s2_by_ff  <= s2_by_in;
         s2_cx_ff  <= s2_cx_in;
         s2_cy_ff  <= s2_cy_in;
         s2_x1_ff  <= s1_x1_ff;
         s2_y1_ff  <= s1_y1_ff;
         s2_x2_ff  <= s1_x2_ff;
         s2_y2_ff  <= s1_y2_ff;
         s2_x3_ff  <= s1_x3_ff;
         s2_y3_ff  <= s1_y3_ff;
         s2_x4_ff  <= s1_x4_ff;
         s2_y4_ff  <= s1_y4_ff;
         s2_eqx_ff <= (s1_x1_ff == s1_x2_ff);
         s2_eqy_ff <= (s1_y1_ff == s1_y2_ff);
      end
   end

   // Stage 3: bounding box test and the six cross product terms.
   logic signed [W-1:0] lox, hix, loy, hiy;
   logic                s3_box_in;
   logic                missx, missy;
   always_comb begin
      lox = (s2_ax_ff < 0) ? s2_x2_ff : s2_x1_ff;
      hix = (s2_ax_ff < 0) ? s2_x1_ff : s2_x2_ff;
      loy = (s2_ay_ff < 0) ? s2_y2_ff : s2_y1_ff;
      hiy = (s2_ay_ff < 0) ? s2_y1_ff : s2_y2_ff;
      if (s2_bx_ff > 0) begin
         missx = (hix < s2_x4_ff) || (s2_x3_ff < lox);
      end else begin
         missx = (hix < s2_x3_ff) || (s2_x4_ff < lox);
      end
      if (s2_by_ff > 0) begin
         missy = (hiy < s2_y4_ff) || (s2_y3_ff < loy);
      end else begin
         missy = (hiy < s2_y3_ff) || (s2_y4_ff < loy);
      end
      s3_box_in = !missx && !missy;
   end

   logic signed [PW-1:0] s3_bycx_ff, s3_bxcy_ff, s3_aybx_ff, s3_axby_ff;
   logic signed [PW-1:0] s3_axcy_ff, s3_aycx_ff;
   logic signed [DW-1:0] s3_ax_ff, s3_ay_ff;
   logic signed [W-1:0]  s3_x1_ff, s3_y1_ff;
   logic                 s3_box_ff, s3_eqx_ff, s3_eqy_ff;
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_bycx_ff <= PW'(s2_by_ff) * PW'(s2_cx_ff);
         s3_bxcy_ff <= PW'(s2_bx_ff) * PW'(s2_cy_ff);
         s3_aybx_ff <= PW'(s2_ay_ff) * PW'(s2_bx_ff);
         s3_axby_ff <= PW'(s2_ax_ff) * PW'(s2_by_ff);
         s3_axcy_ff <= PW'(s2_ax_ff) * PW'(s2_cy_ff);
         s3_aycx_ff <= PW'(s2_ay_ff) * PW'(s2_cx_ff);
         s3_ax_ff   <= s2_ax_ff;
         s3_ay_ff   <= s2_ay_ff;
         s3_x1_ff   <= s2_x1_ff;
         s3_y1_ff   <= s2_y1_ff;
         s3_box_ff  <= s3_box_in;
         s3_eqx_ff  <= s2_eqx_ff;
         s3_eqy_ff  <= s2_eqy_ff;
      end
   end

   // Stage 4: alpha numerator, beta numerator and denominator.
   logic signed [FW-1:0] s4_d_ff, s4_e_ff, s4_f_ff;
   logic signed [DW-1:0] s4_ax_ff, s4_ay_ff;
   logic signed [W-1:0]  s4_x1_ff, s4_y1_ff;
   logic                 s4_box_ff, s4_eqx_ff, s4_eqy_ff;
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s4_d_ff   <= FW'(s3_bycx_ff) - FW'(s3_bxcy_ff);
         s4_e_ff   <= FW'(s3_axcy_ff) - FW'(s3_aycx_ff);
         s4_f_ff   <= FW'(s3_aybx_ff) - FW'(s3_axby_ff);
         s4_ax_ff  <= s3_ax_ff;
         s4_ay_ff  <= s3_ay_ff;
         s4_x1_ff  <= s3_x1_ff;
         s4_y1_ff  <= s3_y1_ff;
         s4_box_ff <= s3_box_ff;
         s4_eqx_ff <= s3_eqx_ff;
         s4_eqy_ff <= s3_eqy_ff;
      end
   end

   // True when a numerator fails the inclusive inside test against the denominator.
   function automatic logic segx_outside(input logic signed [TW-1:0] num,
                                         input logic signed [TW-1:0] den,
                                         input logic signed [TW-1:0] tol);
      logic fail;
      if (den > 0) begin
         fail = (num < tol) || ((den - tol) < num);
      end else begin
         fail = ((-tol) < num) || (num < (den + tol));
      end
      return fail;
   endfunction

   // Stage 5: hit decision, split products of the x and y numerators, |f|.
   logic signed [TW-1:0]  tol_ext;
   logic                  s5_hit_in;
   logic signed [HBW-1:0] d_hi;
   logic signed [LBW-1:0] d_lo;
   logic [FW-1:0]         s5_fabs_in;
   assign tol_ext    = $signed({{(TW-TOL_WIDTH){1'b0}}, tol_ff});
   assign s5_hit_in  = s4_box_ff
                     && !segx_outside(TW'(s4_d_ff), TW'(s4_f_ff), tol_ext)
                     && !segx_outside(TW'(s4_e_ff), TW'(s4_f_ff), tol_ext)
                     && (s4_f_ff != 0);
   assign d_hi       = s4_d_ff[FW-1:LO];
   assign d_lo       = $signed({1'b0, s4_d_ff[LO-1:0]});
   assign s5_fabs_in = s4_f_ff[FW-1] ? (~s4_f_ff + 1'b1) : s4_f_ff;

   logic signed [PHW-1:0] s5_pxh_ff, s5_pyh_ff;
   logic signed [PLW-1:0] s5_pxl_ff, s5_pyl_ff;
   logic [FW-1:0]         s5_fabs_ff;
   logic signed [W-1:0]   s5_x1_ff, s5_y1_ff;
   logic                  s5_fneg_ff, s5_hit_ff, s5_eqx_ff, s5_eqy_ff;
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s5_pxh_ff  <= PHW'(d_hi) * PHW'(s4_ax_ff);
         s5_pyh_ff  <= PHW'(d_hi) * PHW'(s4_ay_ff);
         s5_pxl_ff  <= PLW'(d_lo) * PLW'(s4_ax_ff);
         s5_pyl_ff  <= PLW'(d_lo) * PLW'(s4_ay_ff);
         s5_fabs_ff <= s5_fabs_in;
         s5_fneg_ff <= s4_f_ff[FW-1];
         s5_hit_ff  <= s5_hit_in;
         s5_x1_ff   <= s4_x1_ff;
         s5_y1_ff   <= s4_y1_ff;
         s5_eqx_ff  <= s4_eqx_ff;
         s5_eqy_ff  <= s4_eqy_ff;
      end
   end

   // Stage 6: join the partial products.
   logic signed [NW-1:0] s6_numx_ff, s6_numy_ff;
   logic [FW-1:0]        s6_fabs_ff;
   logic signed [W-1:0]  s6_x1_ff, s6_y1_ff;
   logic                 s6_fneg_ff, s6_hit_ff, s6_eqx_ff, s6_eqy_ff;
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s6_numx_ff <= (NW'(s5_pxh_ff) <<< LO) + NW'(s5_pxl_ff);
         s6_numy_ff <= (NW'(s5_pyh_ff) <<< LO) + NW'(s5_pyl_ff);
         s6_fabs_ff <= s5_fabs_ff;
         s6_fneg_ff <= s5_fneg_ff;
         s6_hit_ff  <= s5_hit_ff;
         s6_x1_ff   <= s5_x1_ff;
         s6_y1_ff   <= s5_y1_ff;
         s6_eqx_ff  <= s5_eqx_ff;
         s6_eqy_ff  <= s5_eqy_ff;
      end
   end

   // Divider stages: index 0 holds the magnitudes, each next index one more
   // quotient bit, most significant first.
   logic [NW-1:0]       dv_remx_ff [0:DW];
   logic [NW-1:0]       dv_remy_ff [0:DW];
   logic [DW-1:0]       dv_qx_ff   [0:DW];
   logic [DW-1:0]       dv_qy_ff   [0:DW];
   logic [FW-1:0]       dv_fabs_ff [0:DW];
   logic signed [W-1:0] dv_x1_ff   [0:DW];
   logic signed [W-1:0] dv_y1_ff   [0:DW];
   logic                dv_negx_ff [0:DW];
   logic                dv_negy_ff [0:DW];
   logic                dv_hit_ff  [0:DW];
   logic                dv_eqx_ff  [0:DW];
   logic                dv_eqy_ff  [0:DW];

   // Stage 7: magnitudes and quotient signs.
   logic [NW-1:0] s7_nx_in, s7_ny_in;
   assign s7_nx_in = s6_numx_ff[NW-1] ? (~s6_numx_ff + 1'b1) : s6_numx_ff;
   assign s7_ny_in = s6_numy_ff[NW-1] ? (~s6_numy_ff + 1'b1) : s6_numy_ff;
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dv_remx_ff[0] <= s7_nx_in;
         dv_remy_ff[0] <= s7_ny_in;
         dv_qx_ff[0]   <= '0;
         dv_qy_ff[0]   <= '0;
         dv_fabs_ff[0] <= s6_fabs_ff;
         dv_x1_ff[0]   <= s6_x1_ff;
         dv_y1_ff[0]   <= s6_y1_ff;
         dv_negx_ff[0] <= s6_numx_ff[NW-1] ^ s6_fneg_ff;
         dv_negy_ff[0] <= s6_numy_ff[NW-1] ^ s6_fneg_ff;
         dv_hit_ff[0]  <= s6_hit_ff;
         dv_eqx_ff[0]  <= s6_eqx_ff;
         dv_eqy_ff[0]  <= s6_eqy_ff;
      end
   end

   genvar j;
   generate
      for (j = 0; j < DW; j++) begin : g_div
         localparam int K = W - j;
         logic [NW-1:0] trial;
         logic          gex, gey;
         // One restoring step: compare against the shifted divisor.
         assign trial = NW'(dv_fabs_ff[j]) << K;
         assign gex   = (dv_remx_ff[j] >= trial);
         assign gey   = (dv_remy_ff[j] >= trial);
         always_ff @(posedge clock) begin
            if (pipe_en) begin
               dv_remx_ff[j+1] <= gex ? (dv_remx_ff[j] - trial) : dv_remx_ff[j];
               dv_remy_ff[j+1] <= gey ? (dv_remy_ff[j] - trial) : dv_remy_ff[j];
               dv_qx_ff[j+1]   <= dv_qx_ff[j] | (DW'(gex) << K);
               dv_qy_ff[j+1]   <= dv_qy_ff[j] | (DW'(gey) << K);
               dv_fabs_ff[j+1] <= dv_fabs_ff[j];
               dv_x1_ff[j+1]   <= dv_x1_ff[j];
               dv_y1_ff[j+1]   <= dv_y1_ff[j];
               dv_negx_ff[j+1] <= dv_negx_ff[j];
               dv_negy_ff[j+1] <= dv_negy_ff[j];
               dv_hit_ff[j+1]  <= dv_hit_ff[j];
               dv_eqx_ff[j+1]  <= dv_eqx_ff[j];
               dv_eqy_ff[j+1]  <= dv_eqy_ff[j];
            end
         end
      end
   endgenerate

   // Final stage: apply the quotient signs.
   logic signed [DW:0]  magx, magy;
   logic signed [DW:0]  fin_qx_ff, fin_qy_ff;
   logic signed [W-1:0] fin_x1_ff, fin_y1_ff;
   logic                fin_hit_ff, fin_eqx_ff, fin_eqy_ff;
   assign magx = $signed({1'b0, dv_qx_ff[DW]});
   assign magy = $signed({1'b0, dv_qy_ff[DW]});
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         fin_qx_ff  <= dv_negx_ff[DW] ? -magx : magx;
         fin_qy_ff  <= dv_negy_ff[DW] ? -magy : magy;
         fin_x1_ff  <= dv_x1_ff[DW];
         fin_y1_ff  <= dv_y1_ff[DW];
         fin_hit_ff <= dv_hit_ff[DW];
         fin_eqx_ff <= dv_eqx_ff[DW];
         fin_eqy_ff <= dv_eqy_ff[DW];
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         fin_valid_ff <= 1'b0;
         for (int i = 0; i <= DW; i++) begin
            dv_valid_ff[i] <= 1'b0;
         end
      end else if (pipe_en) begin
         v1_ff          <= req_valid;
         v2_ff          <= v1_ff;
         v3_ff          <= v2_ff;
         v4_ff          <= v3_ff;
         v5_ff          <= v4_ff;
         v6_ff          <= v5_ff;
         dv_valid_ff[0] <= v6_ff;
         for (int i = 0; i < DW; i++) begin
            dv_valid_ff[i+1] <= dv_valid_ff[i];
         end
         fin_valid_ff   <= dv_valid_ff[DW];
      end
   end

   // Result word: add the start point, pass axis-aligned ends, zero a miss.
   logic signed [SW-1:0] sumx, sumy, x1e, y1e;
   port_word_type        res_x, res_y;
   assign sumx  = SW'(fin_x1_ff) + SW'(fin_qx_ff);
   assign sumy  = SW'(fin_y1_ff) + SW'(fin_qy_ff);
   assign x1e   = SW'(fin_x1_ff);
   assign y1e   = SW'(fin_y1_ff);
   assign res_x = !fin_hit_ff ? '0 : (fin_eqx_ff ? x1e[PORT_WIDTH-1:0] : sumx[PORT_WIDTH-1:0]);
   assign res_y = !fin_hit_ff ? '0 : (fin_eqy_ff ? y1e[PORT_WIDTH-1:0] : sumy[PORT_WIDTH-1:0]);

   // Output register and skid stage.
   logic          rsp_valid_ff, rsp_hit_ff, skid_hit_ff;
   port_word_type rsp_x_ff, rsp_y_ff, skid_x_ff, skid_y_ff;
   logic          take, leave, slot_free;
   assign take      = rsp_valid_ff && !rsp_stall;
   assign leave     = fin_valid_ff && pipe_en;
   assign slot_free = take || !rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff && slot_free) begin
         rsp_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else if (leave && slot_free) begin
         rsp_valid_ff  <= 1'b1;
      end else if (leave) begin
         skid_valid_ff <= 1'b1;
      end else if (take) begin
         rsp_valid_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff && slot_free) begin
         rsp_hit_ff <= skid_hit_ff;
         rsp_x_ff   <= skid_x_ff;
         rsp_y_ff   <= skid_y_ff;
      end else if (leave && slot_free) begin
         rsp_hit_ff <= fin_hit_ff;
         rsp_x_ff   <= res_x;
         rsp_y_ff   <= res_y;
      end
      if (leave && !slot_free) begin
         skid_hit_ff <= fin_hit_ff;
         skid_x_ff   <= res_x;
         skid_y_ff   <= res_y;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_cross_x = rsp_x_ff;
   assign rsp_cross_y = rsp_y_ff;

   // A held skid word always has an occupied output register in front of it.
   `SEGX_ASSERT_NOW(a_skid_behind_rsp, skid_valid_ff, rsp_valid_ff)
   // A missed pair reports the origin.
   `SEGX_ASSERT_NOW(a_miss_zero, rsp_valid_ff && !rsp_hit_ff,
                    rsp_x_ff == '0 && rsp_y_ff == '0)
   // A word leaving into a stalled output lands in the skid stage.
   `SEGX_ASSERT_NEXT(a_skid_fill, leave && rsp_valid_ff && rsp_stall && !skid_valid_ff,
                     skid_valid_ff)
endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the segment intersection core.
`timescale 1ns / 1ps

module tb_top;
   import segx_pkg::*;

   typedef struct packed {
      logic [31:0] x1, y1, x2, y2, x3, y3, x4, y4;
   } seg_pair_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] x;
      logic [31:0] y;
   } crossing_type;

   typedef struct packed {
      seg_pair_type pair;
      logic         typed;
      crossing_type want;
   } stim_row_type;

   localparam int LATENCY      = 42;
   localparam int WATCHDOG_MAX = 4000;
   localparam int RANDOM_ITEMS = 1100;
   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] TWO = 32'h0002_0000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   port_word_type req_first_start_x = '0;
   port_word_type req_first_start_y = '0;
   port_word_type req_first_end_x = '0;
   port_word_type req_first_end_y = '0;
   port_word_type req_second_start_x = '0;
   port_word_type req_second_start_y = '0;
   port_word_type req_second_end_x = '0;
   port_word_type req_second_end_y = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_hit;
   port_word_type rsp_cross_x;
   port_word_type rsp_cross_y;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   tol_word_type  csr_data = '0;

   // Tolerance as last written, mirrored for the predictor.
   logic [31:0]  tolerance = '0;
   crossing_type pending_crossings[$];
   int           error_count = 0;
   int           idle_cycles = 0;
   bit           stall_noise = 1'b1;

   segment_intersection_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_first_start_x(req_first_start_x), .req_first_start_y(req_first_start_y),
      .req_first_end_x(req_first_end_x), .req_first_end_y(req_first_end_y),
      .req_second_start_x(req_second_start_x), .req_second_start_y(req_second_start_y),
      .req_second_end_x(req_second_end_x), .req_second_end_y(req_second_end_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // True when a numerator fails the inclusive inside test against the denominator.
   function automatic bit numerator_outside(logic signed [127:0] num,
                                            logic signed [127:0] den,
                                            logic signed [127:0] tol);
      if (den > 0) begin
         return (num < tol) || (den - tol < num);
      end
      return (-tol < num) || (num < den + tol);
   endfunction

   // Expected crossing of one segment pair under the current tolerance.
   function automatic crossing_type predict_crossing(seg_pair_type p);
      logic signed [63:0]  x1, y1, x2, y2, x3, y3, x4, y4, ax, ay, bx, by, lo, hi;
      logic signed [127:0] wax, way, wbx, wby, wcx, wcy, d, e, f, tol, q;
      crossing_type r;
      bit miss;
      r = '0;
      miss = 1'b0;
      x1 = $signed(p.x1); y1 = $signed(p.y1); x2 = $signed(p.x2); y2 = $signed(p.y2);
      x3 = $signed(p.x3); y3 = $signed(p.y3); x4 = $signed(p.x4); y4 = $signed(p.y4);
      ax = x2 - x1; ay = y2 - y1; bx = x3 - x4; by = y3 - y4;
      // Bounding box overlap in x, then in y.
      lo = (ax < 0) ? x2 : x1;
      hi = (ax < 0) ? x1 : x2;
      if (bx > 0) miss = (hi < x4) || (x3 < lo);
      else miss = (hi < x3) || (x4 < lo);
      lo = (ay < 0) ? y2 : y1;
      hi = (ay < 0) ? y1 : y2;
      if (by > 0) miss |= (hi < y4) || (y3 < lo);
      else miss |= (hi < y3) || (y4 < lo);
      if (miss) return r;
      wax = ax; way = ay; wbx = bx; wby = by;
      wcx = x1 - x3; wcy = y1 - y3;
      d = wby * wcx - wbx * wcy;
      f = way * wbx - wax * wby;
      e = wax * wcy - way * wcx;
      tol = $signed({96'd0, tolerance});
      if (numerator_outside(d, f, tol) || numerator_outside(e, f, tol) || f == 0) begin
         return r;
      end
      r.hit = 1'b1;
      if (x1 == x2) begin
         r.x = p.x1;
      end else begin
         q = (d * wax) / f;
         r.x = p.x1 + q[31:0];
      end
      if (y1 == y2) begin
         r.y = p.y1;
      end else begin
         q = (d * way) / f;
         r.y = p.y1 + q[31:0];
      end
      return r;
   endfunction

   // Random pair: mostly small segments, some large, axis-aligned or parallel, some full-range noise.
   function automatic seg_pair_type random_pair();
      seg_pair_type p;
      int unsigned kind;
      int unsigned span;
      kind = $urandom_range(99);
      p = {$urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
      if (kind < 75) begin
         span = (kind < 60) ? 32'h0004_0000 : 32'h4000_0000;
         p.x1 = $urandom_range(span) - span / 2; p.y1 = $urandom_range(span) - span / 2;
         p.x2 = $urandom_range(span) - span / 2; p.y2 = $urandom_range(span) - span / 2;
         p.x3 = $urandom_range(span) - span / 2; p.y3 = $urandom_range(span) - span / 2;
         p.x4 = $urandom_range(span) - span / 2; p.y4 = $urandom_range(span) - span / 2;
         if (kind < 8) p.x2 = p.x1;
         else if (kind < 16) p.y2 = p.y1;
         else if (kind < 20) begin
            p.x4 = p.x3 + (p.x2 - p.x1);
            p.y4 = p.y3 + (p.y2 - p.y1);
         end
      end
      return p;
   endfunction

   // Random gap length: mostly none, some short, a few long.
   function automatic int gap_length();
      int unsigned k;
      k = $urandom_range(99);
      if (k < 70) return 0;
      if (k < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Drive one word at a falling edge and hold it until accepted.
   task automatic send_pair(seg_pair_type p);
      int gap;
      req_first_start_x <= p.x1; req_first_start_y <= p.y1;
      req_first_end_x <= p.x2; req_first_end_y <= p.y2;
      req_second_start_x <= p.x3; req_second_start_y <= p.y3;
      req_second_end_x <= p.x4; req_second_end_y <= p.y4;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending_crossings.push_back(predict_crossing(p));
      @(negedge clock);
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Write the tolerance register while the core is idle.
   task automatic write_tolerance(logic [31:0] value);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      tolerance = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Let every expected word come back, then wait out the pipeline.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_crossings.size() != 0) @(negedge clock);
      repeat (LATENCY + 8) @(negedge clock);
   endtask

   // Random receiver stall, changed at the falling edge.
   always @(negedge clock) begin
      if (stall_noise && $urandom_range(99) < 20) begin
         rsp_stall <= ($urandom_range(99) < 5) || ($urandom_range(1) == 1);
      end else if (!stall_noise || $urandom_range(99) < 40) begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare every accepted result word with the oldest expectation.
   always @(posedge clock) begin
      crossing_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_crossings.size() == 0) begin
            $display("%0t: unexpected result hit=%0d x=%h y=%h", $realtime,
                     rsp_hit, rsp_cross_x, rsp_cross_y);
            error_count++;
         end else begin
            want = pending_crossings.pop_front();
            if (rsp_hit !== want.hit) begin
               $display("%0t: hit expected %0d actual %0d", $realtime, want.hit, rsp_hit);
               error_count++;
            end
            if (rsp_cross_x !== want.x) begin
               $display("%0t: cross_x expected %h actual %h", $realtime, want.x, rsp_cross_x);
               error_count++;
            end
            if (rsp_cross_y !== want.y) begin
               $display("%0t: cross_y expected %h actual %h", $realtime, want.y, rsp_cross_y);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted word.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Directed rows; typed expectations only where obvious.
   stim_row_type directed[$] = '{
      '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{1'b0, 32'd0, 32'd0}},
      '{'{0, 0, TWO, TWO, 0, TWO, TWO, 0}, 1'b1, '{1'b1, ONE, ONE}},
      '{'{ONE, 0, ONE, TWO, 0, ONE, TWO, ONE}, 1'b1, '{1'b1, ONE, ONE}},
      '{'{0, ONE, TWO, ONE, ONE, 0, ONE, TWO}, 1'b1, '{1'b1, ONE, ONE}},
      '{'{0, 0, TWO, 0, 0, ONE, TWO, ONE}, 1'b1, '{1'b0, 32'd0, 32'd0}},
      '{'{0, 0, ONE, ONE, TWO, TWO, TWO + ONE, TWO + ONE}, 1'b1, '{1'b0, 32'd0, 32'd0}},
      '{'{0, 0, TWO, TWO, ONE, ONE, TWO + ONE, TWO + ONE}, 1'b1, '{1'b0, 32'd0, 32'd0}},
      '{'{0, 0, TWO, 0, ONE, 0, ONE, TWO}, 1'b0, '0},
      '{'{0, 0, ONE, ONE, ONE, ONE, TWO, 0}, 1'b0, '0},
      '{'{0, 0, ONE, ONE, ONE, 0, TWO, TWO}, 1'b0, '0},
      '{'{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
          32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000}, 1'b0, '0},
      '{'{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
          32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff}, 1'b0, '0},
      '{'{32'h8000_0000, 32'h0000_0000, 32'h7fff_ffff, 32'h0000_0001,
          32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff}, 1'b0, '0},
      '{'{32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001,
          32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 32'hffff_ffff}, 1'b0, '0},
      '{'{TWO, TWO, 0, 0, TWO, 0, 0, TWO}, 1'b0, '0},
      '{'{32'hfffe_0000, 0, TWO, 0, 0, 32'hfffe_0000, 0, TWO}, 1'b0, '0}
   };

   initial begin
      stim_row_type row;
      seg_pair_type p;
      logic [31:0] tol_plan[5];
      tol_plan = '{32'hffff_ffff, 32'h0000_0001, 32'd0, 32'h0000_ffff, 32'd0};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at reset tolerance; typed rows check the predictor against the table.
      foreach (directed[i]) begin
         row = directed[i];
         if (row.typed && predict_crossing(row.pair) !== row.want) begin
            $display("%0t: directed row %0d expected %h actual %h", $realtime, i,
                     row.want, predict_crossing(row.pair));
            error_count++;
         end
         send_pair(row.pair);
      end
      drain();

      // Random phases over several tolerance settings.
      foreach (tol_plan[k]) begin
         write_tolerance(k == 2 ? $urandom : tol_plan[k]);
         if (k == 4) stall_noise = 1'b0;
         for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
            p = random_pair();
            send_pair(p);
         end
         drain();
         stall_noise = 1'b1;
      end

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/segx_pkg.sv
hw/rtl/segment_intersection_core.sv
sim/tb_top.sv
